/* rtl/core/ntc_pkg.sv */
// Shared types and constants for the nanosecond / tick conversion block.
// Depends on nothing; used by ntc_div_pipe and ns_tick_time_conversion_unit.
`default_nettype none
package ntc_pkg;

    localparam int unsigned FRAC_BITS = 32;
    localparam int unsigned DIV_STEPS = 64;

    localparam logic [63:0] ONESHOT_MAX = 64'h0000_0000_ffff_ffff;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_DEADLINE = 2'd1;
    localparam logic [1:0] ACT_ONESHOT  = 2'd2;
    localparam logic [1:0] ACT_TIME     = 2'd3;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_DEADLINE = 2'd1;
    localparam logic [1:0] MODE_ONESHOT  = 2'd2;

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] REG_SOURCE_MODE = 8'd0;
    localparam logic [7:0] REG_TICK_NUM    = 8'd1;
    localparam logic [7:0] REG_TICK_DEN    = 8'd2;
    localparam logic [7:0] REG_SCALE       = 8'd3;

    // One slot of the divider pipeline. quo holds the low dividend bits on
    // entry and gathers quotient bits from the bottom as they shift out.
    typedef struct packed {
        logic        valid;
        logic        div_en;
        logic [1:0]  action;
        logic [63:0] rem;
        logic [63:0] quo;
    } div_stage_t;

endpackage
`default_nettype wire

/* rtl/core/ntc_div_pipe.sv */
// Fully pipelined restoring 128/64 divider, one quotient bit per stage.
// Depends on ntc_pkg for the stage type and step count.
`default_nettype none
module ntc_div_pipe (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic [63:0]        divisor,
    input  wire ntc_pkg::div_stage_t in_stage,
    output ntc_pkg::div_stage_t     out_stage
);

    ntc_pkg::div_stage_t stage_reg [ntc_pkg::DIV_STEPS];

    function automatic ntc_pkg::div_stage_t div_step(input ntc_pkg::div_stage_t s,
                                                     input logic [63:0] d);
        ntc_pkg::div_stage_t o;
        logic        carry;
        logic [63:0] shifted;
        logic        take;
        o       = s;
        carry   = s.rem[63];
        shifted = {s.rem[62:0], s.quo[63]};
        take    = carry || (shifted >= d);
        if (s.div_en)
        begin
            o.rem = take ? (shifted - d) : shifted;
            o.quo = {s.quo[62:0], take};
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ntc_pkg::DIV_STEPS; i++)
                stage_reg[i] <= '0;
        end
        else if (en)
        begin
            stage_reg[0] <= div_step(in_stage, divisor);
            for (int i = 1; i < ntc_pkg::DIV_STEPS; i++)
                stage_reg[i] <= div_step(stage_reg[i-1], divisor);
        end
    end

    assign out_stage = stage_reg[ntc_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

/* rtl/core/ns_tick_time_conversion_unit.sv */
// Top level of the nanosecond / tick conversion block.
// Depends on ntc_pkg and ntc_div_pipe.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the command in s_tuser and
//   {tsc_now, ns} in s_tdata. Each beat yields exactly one result beat on
//   m_tvalid/m_tready with the action code in m_tuser and the value in
//   m_tdata. Configuration is written through cfg_valid/cfg_index/cfg_data
//   only while no beat is in flight, a rule for the user that the block does
//   not enforce; cfg_ready is always high. The datapath is a 68-stage
//   pipeline: three stages for the 64x64 product (32x32 partial products,
//   128-bit sum, result select and overflow test), 64 stages of the divider
//   at one quotient bit each, and the output register. One beat is accepted
//   every cycle; when the receiver stalls with a result waiting, the whole
//   pipeline holds and s_tready falls; bubbles are held in place, nothing is
//   lost. Reset clears all valid bits and loads the register reset values.
`default_nettype none
module ns_tick_time_conversion_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // [63:0] ns, [127:64] tsc_now
    input  wire logic         s_tuser,   // [0] cmd
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // [63:0] value
    output logic [1:0]        m_tuser,   // [1:0] action
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    logic [1:0]  mode_reg;
    logic [63:0] num_reg, den_reg, scale_reg;

    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ntc_pkg::MODE_NONE;
            num_reg   <= 64'd0;
            den_reg   <= 64'd1;
            scale_reg <= 64'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ntc_pkg::REG_SOURCE_MODE: mode_reg  <= cfg_data[1:0];
                ntc_pkg::REG_TICK_NUM:    num_reg   <= cfg_data;
                ntc_pkg::REG_TICK_DEN:    den_reg   <= cfg_data;
                ntc_pkg::REG_SCALE:       scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: partial products.
    logic        v1_reg, cmd1_reg;
    logic [63:0] tsc1_reg;
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0] op_x, op_y;

    assign op_x = (s_tuser == ntc_pkg::CMD_READ) ? s_tdata[127:64] : s_tdata[63:0];
    assign op_y = (s_tuser == ntc_pkg::CMD_READ) ? den_reg : scale_reg;

    // Stage 2: full product.
    logic         v2_reg, cmd2_reg;
    logic [63:0]  tsc2_reg;
    logic [127:0] prod_reg;

    // Stage 3: result select, feeds the divider.
    ntc_pkg::div_stage_t s3_reg, s3_next, div_out;
    logic [63:0] ticks, ticks_fix, arm_value;
    logic [1:0]  arm_action;

    always_comb
    begin
        ticks     = prod_reg[64+ntc_pkg::FRAC_BITS-1:ntc_pkg::FRAC_BITS];
        ticks_fix = (ticks == 64'd0) ? 64'd1 : ticks;
        arm_action = ntc_pkg::ACT_NONE;
        arm_value  = 64'd0;
        if (num_reg != 64'd0 && scale_reg != 64'd0)
        begin
            if (mode_reg == ntc_pkg::MODE_DEADLINE)
            begin
                arm_action = ntc_pkg::ACT_DEADLINE;
                arm_value  = tsc2_reg + ticks_fix;
            end
            else if (mode_reg == ntc_pkg::MODE_ONESHOT)
            begin
                arm_action = ntc_pkg::ACT_ONESHOT;
                arm_value  = (ticks_fix > ntc_pkg::ONESHOT_MAX) ? ntc_pkg::ONESHOT_MAX
                                                                 : ticks_fix;
            end
        end

        s3_next.valid  = v2_reg;
        s3_next.div_en = 1'b0;
        s3_next.rem    = 64'd0;
        if (cmd2_reg == ntc_pkg::CMD_READ)
        begin
            s3_next.action = ntc_pkg::ACT_TIME;
            if (num_reg == 64'd0)
                s3_next.quo = 64'd0;
            else if (prod_reg[127:64] >= num_reg)
                s3_next.quo = '1;
            else
            begin
                s3_next.div_en = 1'b1;
                s3_next.rem    = prod_reg[127:64];
                s3_next.quo    = prod_reg[63:0];
            end
        end
        else
        begin
            s3_next.action = arm_action;
            s3_next.quo    = arm_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            s3_reg <= '0;
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            s3_reg <= s3_next;
            m_tvalid <= div_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= s_tuser;
            tsc1_reg <= s_tdata[127:64];
            ll_reg   <= op_x[31:0]  * op_y[31:0];
            lh_reg   <= op_x[31:0]  * op_y[63:32];
            hl_reg   <= op_x[63:32] * op_y[31:0];
            hh_reg   <= op_x[63:32] * op_y[63:32];
            cmd2_reg <= cmd1_reg;
            tsc2_reg <= tsc1_reg;
            prod_reg <= {hh_reg, ll_reg} + {32'd0, lh_reg, 32'd0}
                                         + {32'd0, hl_reg, 32'd0};
            m_tdata  <= div_out.quo;
            m_tuser  <= div_out.action;
        end
    end

    ntc_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .divisor   (num_reg),
        .in_stage  (s3_reg),
        .out_stage (div_out)
    );

endmodule
`default_nettype wire

/* dv/tb_ns_tick_time_conversion_unit.sv */
// Testbench for the nanosecond / tick conversion block: directed and random
// conversions checked against an in-bench predictor. Depends on ntc_pkg and
// ns_tick_time_conversion_unit.
`timescale 1ns / 1ps
module tb_ns_tick_time_conversion_unit;

    localparam int LATENCY     = 68;
    localparam int CYCLE_LIMIT = 900000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [63:0]  cfg_data;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] value;
    } conv_result_t;

    // Predictor copy of the registers.
    logic [1:0]  mdl_mode;
    logic [63:0] mdl_num;
    logic [63:0] mdl_den;
    logic [63:0] mdl_scale;

    conv_result_t pending_q[$];
    int           error_count;
    int           cycle_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;

    ns_tick_time_conversion_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic conv_result_t convert(logic cmd, logic [63:0] ns, logic [63:0] tsc);
        conv_result_t r;
        logic [127:0] prod;
        logic [63:0]  ticks;
        r.action = ntc_pkg::ACT_NONE;
        r.value  = '0;
        if (cmd == ntc_pkg::CMD_READ)
        begin
            r.action = ntc_pkg::ACT_TIME;
            if (mdl_num != 0)
            begin
                prod = {64'd0, tsc} * {64'd0, mdl_den};
                if (prod[127:64] >= mdl_num)
                    r.value = '1;
                else
                    r.value = 64'(prod / {64'd0, mdl_num});
            end
        end
        else if (mdl_num != 0 && mdl_scale != 0)
        begin
            prod  = {64'd0, ns} * {64'd0, mdl_scale};
            ticks = prod[95:32];
            if (ticks == 0)
                ticks = 64'd1;
            if (mdl_mode == ntc_pkg::MODE_DEADLINE)
            begin
                r.action = ntc_pkg::ACT_DEADLINE;
                r.value  = tsc + ticks;
            end
            else if (mdl_mode == ntc_pkg::MODE_ONESHOT)
            begin
                r.action = ntc_pkg::ACT_ONESHOT;
                r.value  = (ticks > ntc_pkg::ONESHOT_MAX) ? ntc_pkg::ONESHOT_MAX : ticks;
            end
        end
        return r;
    endfunction

    task automatic write_reg(logic [7:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            ntc_pkg::REG_SOURCE_MODE: mdl_mode  = data[1:0];
            ntc_pkg::REG_TICK_NUM:    mdl_num   = data;
            ntc_pkg::REG_TICK_DEN:    mdl_den   = data;
            ntc_pkg::REG_SCALE:       mdl_scale = data;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] mode, logic [63:0] num, logic [63:0] den,
                              logic [63:0] scl);
        write_reg(ntc_pkg::REG_SOURCE_MODE, {62'd0, mode});
        write_reg(ntc_pkg::REG_TICK_NUM, num);
        write_reg(ntc_pkg::REG_TICK_DEN, den);
        write_reg(ntc_pkg::REG_SCALE, scl);
    endtask

    // Sends one beat; the valid stays high across back-to-back beats.
    task automatic send_item(logic cmd, logic [63:0] ns, logic [63:0] tsc);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {tsc, ns};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_q.push_back(convert(cmd, ns, tsc));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = v >> $urandom_range(63);
            1: v = '1;
            2: v = 64'd0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        set_config(ntc_pkg::MODE_DEADLINE, 64'd3_000_000_000, 64'd1_000_000_000,
                   64'hC_0000_0000);
        send_item(ntc_pkg::CMD_ARM, 64'd0, 64'd100);
        send_item(ntc_pkg::CMD_ARM, 64'd1000, '1);
        send_item(ntc_pkg::CMD_ARM, '1, '1);
        send_item(ntc_pkg::CMD_READ, 64'd0, 64'd3000);
        send_item(ntc_pkg::CMD_READ, 64'd0, '1);
        send_item(ntc_pkg::CMD_READ, '1, 64'd12345);
        drain();
        set_config(ntc_pkg::MODE_ONESHOT, '1, '1, '1);
        send_item(ntc_pkg::CMD_ARM, 64'd1, 64'd0);
        send_item(ntc_pkg::CMD_ARM, 64'd5, 64'd0);
        send_item(ntc_pkg::CMD_ARM, '1, 64'd7);
        send_item(ntc_pkg::CMD_READ, 64'd0, '1);
        send_item(ntc_pkg::CMD_READ, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
        drain();
        // No source, and the unused mode value, leave arms without action.
        set_config(ntc_pkg::MODE_NONE, 64'd1, 64'd1, 64'd1);
        send_item(ntc_pkg::CMD_ARM, '1, '1);
        drain();
        write_reg(ntc_pkg::REG_SOURCE_MODE, 64'd3);
        send_item(ntc_pkg::CMD_ARM, 64'd77, 64'd1);
        // Unconfigured: zero numerator or zero scale.
        drain();
        set_config(ntc_pkg::MODE_DEADLINE, 64'd0, 64'd5, 64'd1);
        send_item(ntc_pkg::CMD_ARM, 64'd10, 64'd1);
        send_item(ntc_pkg::CMD_READ, 64'd10, 64'd99);
        drain();
        set_config(ntc_pkg::MODE_ONESHOT, 64'd9, 64'd0, 64'd0);
        send_item(ntc_pkg::CMD_ARM, 64'd10, 64'd1);
        send_item(ntc_pkg::CMD_READ, 64'd10, 64'd99);
        drain();
        write_reg(8'd200, 64'd0);
        drain();
    endtask

    task automatic test_random(int count);
        logic [63:0] scl;
        for (int i = 0; i < count; i++)
        begin
            if (i % 90 == 0)
            begin
                drain();
                scl = ($urandom_range(3) == 0) ? rand64() : 64'({$urandom_range(15), $urandom});
                set_config(2'($urandom_range(3)), rand64(), rand64(), scl);
            end
            send_item(1'($urandom_range(1)), rand64(), rand64());
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int i = 0; i < 150; i++)
            send_item(1'($urandom_range(1)), rand64(), rand64());
        drain();
    endtask

    // Receiver: random stalls, plus a long hold-off when asked for.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        conv_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: action %0d value %h", m_tuser, m_tdata);
            end
            else
            begin
                want = pending_q.pop_front();
                if (want.action !== m_tuser || want.value !== m_tdata)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected action %0d value %h, got %0d %h",
                                 want.action, want.value, m_tuser, m_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        error_count    = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        mdl_mode       = ntc_pkg::MODE_NONE;
        mdl_num        = 64'd0;
        mdl_den        = 64'd1;
        mdl_scale      = 64'd0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(440);
        send_idle_pct = 49;
        test_random(440);
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        test_random(440);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        test_random(300);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        if (error_count == 0 && pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
